>>> sv/skst_pkg.sv
// Shared types and codes for the sorted key set table.
package skst_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int KEY_W        = 32;
    localparam int COUNT_OUT_W  = 8;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_DELETE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_PRESENT = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INS,
        S_DEL,
        S_OUT
    } t_state;

endpackage

>>> sv/sorted_key_set_table_top.sv
// Sorted key set table: lookup, insert and delete over a sorted key memory.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+------------------------------
//  command   | in        | start / busy       | i_kind, i_key
//  result    | out       | o_valid (1 cycle)  | o_status, o_entry_count
//
// A transaction scans the memory from entry 0, one read per cycle, up to the
// first key not below the requested one, then an insert or delete moves the
// tail up or down one entry per cycle. Busy holds through the strobe cycle, so
// the next command is accepted in the cycle after the strobe at the earliest.
// Reset (i_rst_n low, synchronous) empties the set; memory contents are kept.
// The receiver cannot stall; busy stays high until the result strobe is done.
module sorted_key_set_table_top
    import skst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_kind,
    input  logic signed [KEY_W-1:0] i_key,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [COUNT_OUT_W-1:0] o_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_pos, n_pos;
    logic               r_pend, n_pend;
    logic [CW-1:0]      r_count, n_count;
    logic [KEY_W-1:0]   r_carry, n_carry;
    t_status            r_status, n_status;
    logic [1:0]         r_kind;
    logic [KEY_W-1:0]   r_key;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [KEY_W-1:0]   w_wdata;
    logic [AW-1:0]      w_raddr;
    logic [KEY_W-1:0]   w_rdata;

    logic [CW-1:0]      w_pos_p1;
    logic [CW-1:0]      w_pos_p2;
    logic               w_at_end;
    logic               w_less;
    logic               w_hit;
    logic               w_decide;
    logic               w_full;
    logic               w_accept;

    skst_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_accept = start && !busy;
    assign w_pos_p1 = r_pos + CW'(1);
    assign w_pos_p2 = r_pos + CW'(2);
    assign w_at_end = (r_pos == r_count);
    assign w_less   = $signed(w_rdata) < $signed(r_key);
    assign w_hit    = !w_at_end && r_pend && (w_rdata == r_key);
    assign w_decide = w_at_end || (r_pend && !w_less);
    assign w_full   = (r_count == CW'(CAPACITY));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_decide) begin
                    priority if (r_kind == KIND_INSERT && !w_hit && !w_full && !w_at_end) begin
                        n_state = S_INS;
                    end else if (r_kind == KIND_DELETE && w_hit) begin
                        n_state = S_DEL;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_INS: begin
                if (w_at_end) begin
                    n_state = S_OUT;
                end
            end
            S_DEL: begin
                if (w_pos_p1 == r_count) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_pos    = r_pos;
        n_pend   = r_pend;
        n_count  = r_count;
        n_carry  = r_carry;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_pos[AW-1:0];
        w_wdata  = r_key;
        w_raddr  = r_pos[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                n_pos  = '0;
                n_pend = 1'b0;
            end
            S_SCAN: begin
                w_raddr = r_pend ? w_pos_p1[AW-1:0] : r_pos[AW-1:0];
                if (!w_decide) begin
                    n_pend = 1'b1;
                    n_pos  = r_pend ? w_pos_p1 : r_pos;
                end else begin
                    unique case (r_kind)
                        KIND_INSERT: begin
                            priority if (w_hit) begin
                                n_status = ST_PRESENT;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status = ST_DONE;
                                w_we     = 1'b1;
                                w_wdata  = r_key;
                                n_carry  = w_rdata;
                                if (w_at_end) begin
                                    n_count = r_count + CW'(1);
                                end else begin
                                    n_pos = w_pos_p1;
                                end
                            end
                        end
                        KIND_DELETE: begin
                            n_status = w_hit ? ST_DONE : ST_ABSENT;
                        end
                        default: begin
                            n_status = w_hit ? ST_DONE : ST_ABSENT;
                        end
                    endcase
                end
            end
            S_INS: begin
                w_we    = 1'b1;
                w_wdata = r_carry;
                n_carry = w_rdata;
                w_raddr = w_pos_p1[AW-1:0];
                if (w_at_end) begin
                    n_count = r_count + CW'(1);
                end else begin
                    n_pos = w_pos_p1;
                end
            end
            S_DEL: begin
                w_raddr = w_pos_p2[AW-1:0];
                if (w_pos_p1 == r_count) begin
                    n_count = r_count - CW'(1);
                end else begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata;
                    n_pos   = w_pos_p1;
                end
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        busy          = (r_state != S_IDLE);
        o_valid       = (r_state == S_OUT);
        o_status      = r_status;
        o_entry_count = COUNT_OUT_W'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_pend  <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_pend  <= n_pend;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry  <= n_carry;
        r_status <= n_status;
        if (w_accept) begin
            r_kind <= i_kind;
            r_key  <= i_key;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> w_full)
        else $error("store full reported below capacity");

    a_count_moves_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_state == S_OUT))
        else $error("entry count changed outside result cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy not raised after accepted transaction");

endmodule

>>> sv/skst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module skst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> tb/tb_sorted_key_set_table_top.sv
// Sorted key set table testbench: directed and random commands checked against a table or queue model.
`timescale 1ns / 1ps

module tb_sorted_key_set_table_top;
    import skst_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1830;
    localparam int PRINT_CAP    = 40;

    localparam logic [1:0] KIND_ALIAS = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN   = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_ZERO  = 32'sh0000_0000;
    localparam logic signed [KEY_W-1:0] KEY_ONE   = 32'sh0000_0001;
    localparam logic signed [KEY_W-1:0] KEY_M_ONE = 32'shFFFF_FFFF;

    typedef struct packed {
        t_status               status;
        logic [COUNT_OUT_W-1:0] count;
    } t_outcome;

    typedef struct packed {
        logic [1:0]             kind;
        logic signed [KEY_W-1:0] key;
        bit                     typed;
        t_status                status;
        logic [COUNT_OUT_W-1:0] count;
    } t_row;

    typedef enum {PH_FILL, PH_FULL_PROBE, PH_CHURN, PH_DRAIN} t_mix;

    localparam int N_ROWS = 22;
    localparam t_row DIRECTED_ROWS [0:N_ROWS-1] = '{
        '{KIND_LOOKUP, KEY_ZERO,       1'b1, ST_ABSENT,  8'd0},
        '{KIND_DELETE, KEY_ZERO,       1'b1, ST_ABSENT,  8'd0},
        '{KIND_INSERT, KEY_MIN,        1'b1, ST_DONE,    8'd1},
        '{KIND_INSERT, KEY_MAX,        1'b1, ST_DONE,    8'd2},
        '{KIND_INSERT, KEY_ZERO,       1'b1, ST_DONE,    8'd3},
        '{KIND_INSERT, KEY_ZERO,       1'b1, ST_PRESENT, 8'd3},
        '{KIND_INSERT, KEY_M_ONE,      1'b1, ST_DONE,    8'd4},
        '{KIND_INSERT, KEY_ONE,        1'b1, ST_DONE,    8'd5},
        '{KIND_LOOKUP, KEY_MIN,        1'b1, ST_DONE,    8'd5},
        '{KIND_LOOKUP, KEY_MAX,        1'b1, ST_DONE,    8'd5},
        '{KIND_ALIAS,  KEY_M_ONE,      1'b1, ST_DONE,    8'd5},
        '{KIND_ALIAS,  32'sd2,         1'b1, ST_ABSENT,  8'd5},
        '{KIND_LOOKUP, 32'sh7FFF_FFFE, 1'b1, ST_ABSENT,  8'd5},
        '{KIND_DELETE, KEY_ZERO,       1'b1, ST_DONE,    8'd4},
        '{KIND_DELETE, KEY_ZERO,       1'b1, ST_ABSENT,  8'd4},
        '{KIND_DELETE, KEY_MAX,        1'b1, ST_DONE,    8'd3},
        '{KIND_DELETE, KEY_MIN,        1'b1, ST_DONE,    8'd2},
        '{KIND_INSERT, 32'sh5555_5555, 1'b0, ST_DONE,    8'd0},
        '{KIND_INSERT, 32'shAAAA_AAAA, 1'b0, ST_DONE,    8'd0},
        '{KIND_LOOKUP, 32'shAAAA_AAAA, 1'b0, ST_DONE,    8'd0},
        '{KIND_DELETE, KEY_M_ONE,      1'b0, ST_DONE,    8'd0},
        '{KIND_DELETE, KEY_ONE,        1'b0, ST_DONE,    8'd0}
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              i_kind;
    logic signed [KEY_W-1:0] i_key;
    logic                    o_valid;
    logic [1:0]              o_status;
    logic [COUNT_OUT_W-1:0]  o_entry_count;

    logic signed [KEY_W-1:0] held_keys [$];
    t_outcome                pending_outcomes [$];
    int                      mismatch_count = 0;
    int                      burst_left = 0;

    sorted_key_set_table_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(30_000_000);
        $display("** sorted_key_set_table_top: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP) $display("%0t: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic t_outcome set_op_outcome(input logic [1:0] kind,
                                                 input logic signed [KEY_W-1:0] key);
        t_outcome res;
        int       pos;
        bit       hit;
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] < key) pos++;
        hit = (pos < held_keys.size()) && (held_keys[pos] == key);
        case (kind)
            KIND_INSERT: begin
                if (hit) begin
                    res.status = ST_PRESENT;
                end else if (held_keys.size() >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    held_keys.insert(pos, key);
                    res.status = ST_DONE;
                end
            end
            KIND_DELETE: begin
                if (!hit) begin
                    res.status = ST_ABSENT;
                end else begin
                    held_keys.delete(pos);
                    res.status = ST_DONE;
                end
            end
            default: res.status = hit ? ST_DONE : ST_ABSENT;
        endcase
        res.count = COUNT_OUT_W'(held_keys.size());
        return res;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key(input int hit_pct);
        int r;
        logic signed [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (held_keys.size() > 0 && r < hit_pct) begin
            return held_keys[$urandom_range(0, held_keys.size() - 1)];
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            case ($urandom_range(0, 4))
                0:       k = KEY_MIN;
                1:       k = KEY_MAX;
                2:       k = KEY_ZERO;
                3:       k = KEY_ONE;
                default: k = KEY_M_ONE;
            endcase
        end else if (r < 30 && held_keys.size() > 0) begin
            k = held_keys[$urandom_range(0, held_keys.size() - 1)];
            k = $urandom_range(0, 1) ? k + 1 : k - 1;
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    task automatic pace_sender();
        int r;
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) gap = $urandom_range(1, 4);
            else if (r < 90) gap = $urandom_range(5, 40);
            else gap = $urandom_range(41, 160);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic issue_command(input logic [1:0] kind, input logic signed [KEY_W-1:0] key,
                                 input bit typed, input t_outcome typed_out);
        t_outcome predicted;
        i_kind <= kind;
        i_key  <= key;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = set_op_outcome(kind, key);
        pending_outcomes.push_back(typed ? typed_out : predicted);
        pace_sender();
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result with no transaction pending");
            end else begin
                want = pending_outcomes.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_entry_count !== want.count)
                    report_mismatch($sformatf("entry_count %0d, want %0d",
                                              o_entry_count, want.count));
            end
        end
    end

    initial begin
        t_mix                    mix;
        int                      mix_left;
        int                      sent;
        int                      r;
        int                      hit_pct;
        logic [1:0]              op;
        t_outcome                typed_out;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_kind  <= KIND_LOOKUP;
        i_key   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < N_ROWS; n++) begin
            typed_out.status = DIRECTED_ROWS[n].status;
            typed_out.count  = DIRECTED_ROWS[n].count;
            issue_command(DIRECTED_ROWS[n].kind, DIRECTED_ROWS[n].key,
                          DIRECTED_ROWS[n].typed, typed_out);
        end

        mix      = PH_FILL;
        mix_left = 0;
        for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
            case (mix)
                PH_FILL: begin
                    if (held_keys.size() >= CAPACITY) begin
                        mix      = PH_FULL_PROBE;
                        mix_left = 24;
                    end
                end
                PH_FULL_PROBE: begin
                    if (mix_left == 0) begin
                        mix      = PH_CHURN;
                        mix_left = 150;
                    end
                end
                PH_CHURN: begin
                    if (mix_left == 0) mix = PH_DRAIN;
                end
                default: begin
                    if (held_keys.size() == 0) mix = PH_FILL;
                end
            endcase
            if (mix_left > 0) mix_left--;

            r = $urandom_range(0, 99);
            case (mix)
                PH_FILL: begin
                    op = r < 85 ? KIND_INSERT : r < 93 ? KIND_LOOKUP : KIND_DELETE;
                    hit_pct = 10;
                end
                PH_FULL_PROBE: begin
                    op = r < 60 ? KIND_INSERT : r < 80 ? KIND_LOOKUP : KIND_DELETE;
                    hit_pct = 50;
                end
                PH_CHURN: begin
                    op = r < 35 ? KIND_INSERT : r < 70 ? KIND_DELETE : KIND_LOOKUP;
                    hit_pct = 50;
                end
                default: begin
                    op = r < 85 ? KIND_DELETE : r < 93 ? KIND_LOOKUP : KIND_INSERT;
                    hit_pct = 85;
                end
            endcase
            if (op == KIND_LOOKUP && $urandom_range(0, 3) == 0) op = KIND_ALIAS;
            issue_command(op, pick_key(hit_pct), 1'b0, typed_out);
        end

        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (CAPACITY + 16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** sorted_key_set_table_top: PASSED **");
        end else begin
            $display("** sorted_key_set_table_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> sorted_key_set_table_top.f
sv/skst_pkg.sv
sv/skst_ram.sv
sv/sorted_key_set_table_top.sv
tb/tb_sorted_key_set_table_top.sv
